// ===== design/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

	localparam int KEY_W = 16;
	localparam int PAY_W = 16;
	localparam int OP_W  = 2;
	localparam int ST_W  = 2;
	localparam int OCC_W = 7;

	localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
	localparam logic [OP_W-1:0] OP_EXTRACT = 2'd1;
	localparam logic [OP_W-1:0] OP_PEEK    = 2'd2;
	localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic             ins;
		logic             ext;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] pay;
	} ctrl_t;

endpackage

`default_nettype wire

// ===== design/spq_cell.sv =====
`default_nettype none

// One slot of the sorted chain. Shifts right on insert, left on extract.
module spq_cell (
	input  wire                          clk,
	input  wire  spq_pkg::ctrl_t         ctrl,
	input  wire                          occ,
	input  wire                          lt_left,
	input  wire  [spq_pkg::KEY_W-1:0]    left_key,
	input  wire  [spq_pkg::PAY_W-1:0]    left_pay,
	input  wire  [spq_pkg::KEY_W-1:0]    right_key,
	input  wire  [spq_pkg::PAY_W-1:0]    right_pay,
	output logic                         lt,
	output logic [spq_pkg::KEY_W-1:0]    key,
	output logic [spq_pkg::PAY_W-1:0]    pay
);

	logic [spq_pkg::KEY_W-1:0] key_q;
	logic [spq_pkg::PAY_W-1:0] pay_q;

	// keys are sorted, so lt is a thermometer along the chain
	assign lt  = occ && (key_q < ctrl.key);
	assign key = key_q;
	assign pay = pay_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (!lt) begin
				if (lt_left) begin
					key_q <= ctrl.key;
					pay_q <= ctrl.pay;
				end else begin
					key_q <= left_key;
					pay_q <= left_pay;
				end
			end
		end else if (ctrl.ext) begin
			key_q <= right_key;
			pay_q <= right_pay;
		end
	end

endmodule

`default_nettype wire

// ===== design/sorted_priority_queue_lifo_ties.sv =====
`default_nettype none

// Sorted min-priority queue, ties served newest first.
// Slave stream: one request word per transfer; s_tuser carries the opcode
// (insert, extract min, peek min, clear), s_tdata the key and payload.
// Master stream: exactly one result word per request; m_tuser carries the
// status (ok, empty, full), m_tdata the front payload, front key and the
// occupancy after the request.
// The entries sit in a chain of CAPACITY cells; every cell compares its key
// with the incoming key in parallel and shifts toward its neighbor, so a
// request takes effect in the cycle it is accepted and its result is valid
// the next cycle. One request per cycle is sustained with m_tready high.
// The result sits in an output register; while the receiver stalls with a
// result pending, s_tready drops and nothing further is accepted. When the
// register is being drained in the same cycle, a new request is taken.
// Reset empties the queue (count to zero) and clears the output valid;
// the cell contents are left as they are and never read until written.
module sorted_priority_queue_lifo_ties #(
	parameter int CAPACITY = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // entry_key[15:0], entry_payload[31:16]
	input  wire  [1:0]  s_tuser,   // op[1:0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,   // front_payload[15:0], front_key[31:16],
	                               // occupancy[38:32], zero[39]
	output logic [1:0]  m_tuser    // status[1:0]
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0] count_q;
	logic          m_tvalid_q;
	logic [spq_pkg::PAY_W-1:0] out_pay_q;
	logic [spq_pkg::KEY_W-1:0] out_key_q;
	logic [spq_pkg::OCC_W-1:0] out_occ_q;
	logic [spq_pkg::ST_W-1:0]  out_st_q;

	logic                      take;
	logic [spq_pkg::OP_W-1:0]  op;
	logic [spq_pkg::KEY_W-1:0] in_key;
	logic [spq_pkg::PAY_W-1:0] in_pay;
	logic                      empty, full;
	spq_pkg::ctrl_t            ctrl;

	logic [spq_pkg::KEY_W-1:0] key_c [CAPACITY];
	logic [spq_pkg::PAY_W-1:0] pay_c [CAPACITY];
	logic [CAPACITY-1:0]       lt_c;

	logic [CW-1:0]             count_d;
	logic [spq_pkg::PAY_W-1:0] res_pay;
	logic [spq_pkg::KEY_W-1:0] res_key;
	logic [spq_pkg::ST_W-1:0]  res_st;

	assign s_tready = !m_tvalid_q || m_tready;
	assign take     = s_tvalid && s_tready;
	assign op       = s_tuser;
	assign in_key   = s_tdata[15:0];
	assign in_pay   = s_tdata[31:16];
	assign empty    = (count_q == '0);
	assign full     = (count_q == CW'(CAPACITY));

	assign ctrl.ins = take && (op == spq_pkg::OP_INSERT) && !full;
	assign ctrl.ext = take && (op == spq_pkg::OP_EXTRACT) && !empty;
	assign ctrl.key = in_key;
	assign ctrl.pay = in_pay;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                      lt_l;
		logic [spq_pkg::KEY_W-1:0] lk, rk;
		logic [spq_pkg::PAY_W-1:0] lp, rp;

		if (i == 0) begin : g_head
			assign lt_l = 1'b1;
			assign lk   = in_key;
			assign lp   = in_pay;
		end else begin : g_body
			assign lt_l = lt_c[i-1];
			assign lk   = key_c[i-1];
			assign lp   = pay_c[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign rk = '0;
			assign rp = '0;
		end else begin : g_mid
			assign rk = key_c[i+1];
			assign rp = pay_c[i+1];
		end

		spq_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.occ       (CW'(i) < count_q),
			.lt_left   (lt_l),
			.left_key  (lk),
			.left_pay  (lp),
			.right_key (rk),
			.right_pay (rp),
			.lt        (lt_c[i]),
			.key       (key_c[i]),
			.pay       (pay_c[i])
		);
	end

	always_comb begin
		count_d = count_q;
		res_pay = '0;
		res_key = '0;
		res_st  = spq_pkg::ST_OK;
		unique case (op)
			spq_pkg::OP_INSERT: begin
				if (full) begin
					res_st  = spq_pkg::ST_FULL;
					res_pay = pay_c[0];
					res_key = key_c[0];
				end else begin
					count_d = count_q + 1'b1;
					// new entry lands in front unless the head key is smaller
					if (lt_c[0]) begin
						res_pay = pay_c[0];
						res_key = key_c[0];
					end else begin
						res_pay = in_pay;
						res_key = in_key;
					end
				end
			end
			spq_pkg::OP_EXTRACT, spq_pkg::OP_PEEK: begin
				if (empty) begin
					res_st = spq_pkg::ST_EMPTY;
				end else begin
					res_pay = pay_c[0];
					res_key = key_c[0];
					if (op == spq_pkg::OP_EXTRACT) begin
						count_d = count_q - 1'b1;
					end
				end
			end
			spq_pkg::OP_CLEAR: begin
				count_d = '0;
			end
			default: begin
				count_d = count_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (take) begin
				count_q    <= count_d;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_pay_q <= res_pay;
			out_key_q <= res_key;
			out_occ_q <= spq_pkg::OCC_W'(count_d);
			out_st_q  <= res_st;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, out_occ_q, out_key_q, out_pay_q};
	assign m_tuser  = out_st_q;

endmodule

`default_nettype wire

// ===== bench/tb_sorted_priority_queue_lifo_ties.sv =====
`default_nettype none

module tb_sorted_priority_queue_lifo_ties;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY       = 64;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_ITEMS   = 900;

	typedef struct packed {
		logic [spq_pkg::OP_W-1:0]  op;
		logic [spq_pkg::KEY_W-1:0] key;
		logic [spq_pkg::PAY_W-1:0] pay;
	} request_t;

	typedef struct packed {
		logic [spq_pkg::PAY_W-1:0] pay;
		logic [spq_pkg::KEY_W-1:0] key;
		logic [spq_pkg::ST_W-1:0]  st;
		logic [spq_pkg::OCC_W-1:0] occ;
	} front_t;

	typedef enum {KEYS_ANY, KEYS_TIED, KEYS_EDGE} key_spread_t;
	typedef enum {SEG_FILL, SEG_DRAIN, SEG_MIXED, SEG_NOISE} segment_t;
	typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_mode_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;    // entry_key[15:0], entry_payload[31:16]
	logic [1:0]  s_tuser  = '0;    // op[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;          // front_payload[15:0], front_key[31:16], occupancy[38:32]
	logic [1:0]  m_tuser;          // status[1:0]

	sorted_priority_queue_lifo_ties #(.CAPACITY(CAPACITY)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	// shadow copy of the sorted chain
	logic [spq_pkg::KEY_W-1:0] shadow_keys [CAPACITY];
	logic [spq_pkg::PAY_W-1:0] shadow_pays [CAPACITY];
	int               shadow_count = 0;

	request_t request_backlog [$];
	front_t   expected_fronts [$];
	int       mismatches = 0;
	int       burst_left = 0;
	int       gap_left = 0;
	int       idle_cycles = 0;
	int       ready_left = 0;
	int       ready_tick = 0;
	ready_mode_t ready_mode = READY_ALWAYS;

	function automatic front_t front_of(input logic [spq_pkg::ST_W-1:0] st);
		front_t f;
		f = '0;
		f.st = st;
		if (shadow_count > 0) begin
			f.pay = shadow_pays[0];
			f.key = shadow_keys[0];
		end
		return f;
	endfunction

	task automatic serve_request(input request_t r, output front_t f);
		int pos;
		f = '0;
		case (r.op)
			spq_pkg::OP_INSERT: begin
				if (shadow_count >= CAPACITY) begin
					f = front_of(spq_pkg::ST_FULL);
				end else begin
					// new entry goes ahead of equal keys
					pos = 0;
					while (pos < shadow_count && shadow_keys[pos] < r.key)
						pos++;
					for (int i = shadow_count; i > pos; i--) begin
						shadow_keys[i] = shadow_keys[i-1];
						shadow_pays[i] = shadow_pays[i-1];
					end
					shadow_keys[pos] = r.key;
					shadow_pays[pos] = r.pay;
					shadow_count++;
					f = front_of(spq_pkg::ST_OK);
				end
			end
			spq_pkg::OP_EXTRACT: begin
				if (shadow_count == 0) begin
					f.st = spq_pkg::ST_EMPTY;
				end else begin
					f = front_of(spq_pkg::ST_OK);
					for (int i = 1; i < shadow_count; i++) begin
						shadow_keys[i-1] = shadow_keys[i];
						shadow_pays[i-1] = shadow_pays[i];
					end
					shadow_count--;
				end
			end
			spq_pkg::OP_PEEK: begin
				if (shadow_count == 0)
					f.st = spq_pkg::ST_EMPTY;
				else
					f = front_of(spq_pkg::ST_OK);
			end
			default: begin
				shadow_count = 0;
				f.st = spq_pkg::ST_OK;
			end
		endcase
		f.occ = spq_pkg::OCC_W'(shadow_count);
	endtask

	task automatic queue_request(input logic [spq_pkg::OP_W-1:0] op,
			input logic [spq_pkg::KEY_W-1:0] key, input logic [spq_pkg::PAY_W-1:0] pay);
		request_t r;
		r.op = op;
		r.key = key;
		r.pay = pay;
		request_backlog.push_back(r);
	endtask

	function automatic logic [spq_pkg::KEY_W-1:0] pick_key(input key_spread_t spread);
		logic [spq_pkg::KEY_W-1:0] k;
		case (spread)
			KEYS_TIED: k = spq_pkg::KEY_W'($urandom_range(0, 7));
			KEYS_EDGE: begin
				case ($urandom_range(0, 3))
					0: k = '0;
					1: k = 16'h0001;
					2: k = 16'hFFFE;
					default: k = '1;
				endcase
			end
			default: k = spq_pkg::KEY_W'($urandom_range(0, 16'hFFFF));
		endcase
		return k;
	endfunction

	task automatic queue_random_segment();
		segment_t    seg;
		key_spread_t spread;
		int          len;
		int          ins_pct;
		int          roll;
		logic [spq_pkg::OP_W-1:0] op;
		seg = segment_t'($urandom_range(0, 3));
		spread = key_spread_t'($urandom_range(0, 2));
		len = $urandom_range(20, 120);
		case (seg)
			SEG_FILL:  ins_pct = 85;
			SEG_DRAIN: ins_pct = 20;
			default:   ins_pct = 50;
		endcase
		for (int n = 0; n < len; n++) begin
			roll = $urandom_range(0, 99);
			if (seg == SEG_NOISE)
				op = spq_pkg::OP_W'($urandom_range(0, 3));
			else if (roll < 1)
				op = spq_pkg::OP_CLEAR;
			else if (roll < ins_pct)
				op = spq_pkg::OP_INSERT;
			else if (roll < ins_pct + (100 - ins_pct) * 3 / 4)
				op = spq_pkg::OP_EXTRACT;
			else
				op = spq_pkg::OP_PEEK;
			queue_request(op, pick_key(spread),
			              spq_pkg::PAY_W'($urandom_range(0, 16'hFFFF)));
		end
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// driver: one word per handshake, bursts separated by random gaps
	always @(posedge clk) begin
		front_t predicted;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				serve_request(request_backlog[0], predicted);
				expected_fronts.push_back(predicted);
				void'(request_backlog.pop_front());
			end
			if (s_tvalid && !s_tready) begin
				// word still waiting, hold it
			end else if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (request_backlog.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tuser <= request_backlog[0].op;
				s_tdata <= {request_backlog[0].pay, request_backlog[0].key};
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
					                                         : $urandom_range(1, 20);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver backpressure, switches pattern every so often
	always @(posedge clk) begin
		if (arst_n) begin
			ready_tick++;
			if (ready_left == 0) begin
				ready_mode = ready_mode_t'($urandom_range(0, 3));
				ready_left = $urandom_range(16, 128);
			end else begin
				ready_left--;
			end
			case (ready_mode)
				READY_ALWAYS:   m_tready <= 1'b1;
				READY_COIN:     m_tready <= 1'($urandom_range(0, 1));
				READY_SPARSE:   m_tready <= ($urandom_range(0, 7) == 0);
				default:        m_tready <= (ready_tick % 5) >= 2;
			endcase
		end
	end

	always @(posedge clk) begin
		front_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_fronts.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual tdata %0h tuser %0h",
				         $time, m_tdata, m_tuser);
				mismatches++;
			end else begin
				want = expected_fronts.pop_front();
				check_field("front_payload", 32'(want.pay), 32'(m_tdata[15:0]));
				check_field("front_key", 32'(want.key), 32'(m_tdata[31:16]));
				check_field("occupancy", 32'(want.occ), 32'(m_tdata[38:32]));
				check_field("tdata pad", 0, 32'(m_tdata[39]));
				check_field("status", 32'(want.st), 32'(m_tuser));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, idle_cycles);
				$display("FAILED: results differ");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		// empty queue cases
		queue_request(spq_pkg::OP_PEEK, 16'h1111, 16'h2222);
		queue_request(spq_pkg::OP_EXTRACT, 16'hFFFF, 16'hFFFF);
		queue_request(spq_pkg::OP_CLEAR, 16'h0000, 16'h0000);
		// extremes and ties, newest of equal keys first
		queue_request(spq_pkg::OP_INSERT, 16'h1234, 16'hAAAA);
		queue_request(spq_pkg::OP_INSERT, 16'hFFFF, 16'hFFFF);
		queue_request(spq_pkg::OP_INSERT, 16'h0000, 16'h0000);
		queue_request(spq_pkg::OP_INSERT, 16'h0000, 16'h0001);
		queue_request(spq_pkg::OP_INSERT, 16'h0000, 16'h5555);
		queue_request(spq_pkg::OP_PEEK, 16'h0000, 16'h0000);
		queue_request(spq_pkg::OP_EXTRACT, 16'h0000, 16'h0000);
		queue_request(spq_pkg::OP_EXTRACT, 16'h0000, 16'h0000);
		queue_request(spq_pkg::OP_EXTRACT, 16'h0000, 16'h0000);
		queue_request(spq_pkg::OP_INSERT, 16'h8000, 16'h00FF);
		queue_request(spq_pkg::OP_INSERT, 16'h8000, 16'hFF00);
		queue_request(spq_pkg::OP_INSERT, 16'h7FFF, 16'h8001);
		queue_request(spq_pkg::OP_EXTRACT, 16'h0000, 16'h0000);
		queue_request(spq_pkg::OP_EXTRACT, 16'h0000, 16'h0000);
		queue_request(spq_pkg::OP_CLEAR, 16'h0000, 16'h0000);
		queue_request(spq_pkg::OP_PEEK, 16'h0000, 16'h0000);
		queue_request(spq_pkg::OP_INSERT, 16'hFFFF, 16'h0000);
		queue_request(spq_pkg::OP_EXTRACT, 16'h0000, 16'h0000);
		queue_request(spq_pkg::OP_EXTRACT, 16'h0000, 16'h0000);
		while (request_backlog.size() < RANDOM_ITEMS)
			queue_random_segment();

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (request_backlog.size() > 0 || expected_fronts.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue_lifo_ties.sv
bench/tb_sorted_priority_queue_lifo_ties.sv
